// ----- rtl/tse_pkg.sv -----
// ----------------------------------------------------------------------------
// TLS server name extractor package
// Word types, status codes and fixed byte counts that are shared by the
// extractor and its checker.
// ----------------------------------------------------------------------------
package tse_pkg;

	// Bytes ahead of the session ID length: the record header, the handshake
	// header, the client version and the random.
	localparam logic [15:0] HEAD_BYTES    = 16'd43;
	// Bytes of the server name extension between its type and the name length.
	localparam logic [15:0] SNI_HEAD_REST = 16'd5;
	// The compression methods skip also covers the two extensions length bytes.
	localparam logic [8:0]  CM_EXTRA      = 9'd2;

	// Result status codes.
	localparam logic [1:0] ST_NAME_BYTE = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_TRUNCATED = 2'd2;
	localparam logic [1:0] ST_EMPTY     = 2'd3;

	// One byte of the ClientHello record.
	typedef struct packed {
		logic [7:0] hello_byte;
		logic       record_last;
	} hello_word_t;

	// One result word.
	typedef struct packed {
		logic [7:0] name_byte;
		logic [1:0] status;
		logic       name_last;
	} sni_word_t;

endpackage

// ----- rtl/tls_sni_extractor_top.sv -----
// ----------------------------------------------------------------------------
// TLS server name extractor
// Walks a ClientHello record byte by byte and emits the server name bytes,
// or one status word when there is no name, the name is cut short or empty.
// ----------------------------------------------------------------------------
// Usage.
// The hello channel (hello_valid, hello_stall, hello_word) carries one byte of
// the ClientHello record per word, starting at the record header, with
// record_last set on the final byte. The sni channel (sni_valid, sni_stall,
// sni_word) carries the results: one word per server name byte, or a single
// status word, and every record closes with exactly one word that has
// name_last set. Bytes that follow the closing word are dropped until
// record_last, after which the next byte starts a new record.
// Throughput is one byte per cycle while hello_stall is low. Each result is
// registered in the output register, or in the skid register behind it.
// When the receiver stalls, the output register holds its word and one more
// result can land in a skid register; only then is hello_stall raised, and it
// drops as soon as the skid register has moved into the output register.
// Reset (arst_n low) clears the valid flags of both registers and returns the
// parser to the start of a record.
// ----------------------------------------------------------------------------
module tls_sni_extractor_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                hello_valid,
	output logic                hello_stall,
	input  tse_pkg::hello_word_t hello_word,
	output logic                sni_valid,
	input  logic                sni_stall,
	output tse_pkg::sni_word_t  sni_word
);

	typedef enum logic [3:0] {
		PH_SID_LEN = 4'd0,
		PH_SKIP    = 4'd1,
		PH_CS_HI   = 4'd2,
		PH_CS_LO   = 4'd3,
		PH_CM_LEN  = 4'd4,
		PH_ET_HI   = 4'd5,
		PH_ET_LO   = 4'd6,
		PH_EL_HI   = 4'd7,
		PH_EL_LO   = 4'd8,
		PH_NL_HI   = 4'd9,
		PH_NL_LO   = 4'd10,
		PH_NAME    = 4'd11
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [15:0] skip_q, skip_d;
	logic [7:0]  hold_q, hold_d;
	logic [15:0] rem_q, rem_d;
	logic        done_q, done_d;

	logic               res_valid;
	tse_pkg::sni_word_t res;
	logic               accept;
	logic               pop;
	logic               skid_valid_q;
	tse_pkg::sni_word_t skid_q;
	logic               out_valid_q;
	tse_pkg::sni_word_t out_q;

	assign accept      = hello_valid && !hello_stall;
	assign pop         = out_valid_q && !sni_stall;
	assign hello_stall = skid_valid_q;
	assign sni_valid   = out_valid_q;
	assign sni_word    = out_q;

	// Parse step: next state and the result that this byte causes.
	always_comb begin
		logic [7:0]  b;
		logic [15:0] v;
		logic [8:0]  cm_count;
		logic        in_sni;
		b        = hello_word.hello_byte;
		v        = {hold_q, b};
		cm_count = {1'b0, b} + tse_pkg::CM_EXTRA;
		in_sni   = 1'b0;
		phase_d  = phase_q;
		skip_d   = skip_q;
		hold_d   = hold_q;
		rem_d    = rem_q;
		done_d   = done_q;
		res_valid = 1'b0;
		res       = '0;
		if (done_q) begin
			if (hello_word.record_last) begin
				phase_d = PH_SKIP;
				skip_d  = tse_pkg::HEAD_BYTES;
				hold_d  = '0;
				rem_d   = '0;
				done_d  = 1'b0;
			end
		end else begin
			unique case (phase_q)
				PH_SID_LEN: begin
					if (b == 8'd0) begin
						phase_d = PH_CS_HI;
					end else begin
						skip_d  = {8'd0, b};
						hold_d  = {4'd0, PH_CS_HI};
						phase_d = PH_SKIP;
					end
				end
				PH_SKIP: begin
					if (skip_q <= 16'd1) begin
						skip_d  = '0;
						phase_d = phase_t'(hold_q[3:0]);
					end else begin
						skip_d = skip_q - 16'd1;
					end
				end
				PH_CS_HI, PH_ET_HI, PH_EL_HI, PH_NL_HI: begin
					hold_d  = b;
					phase_d = phase_t'(phase_q + 4'd1);
				end
				PH_CS_LO: begin
					if (v == 16'd0) begin
						phase_d = PH_CM_LEN;
					end else begin
						skip_d  = v;
						hold_d  = {4'd0, PH_CM_LEN};
						phase_d = PH_SKIP;
					end
				end
				PH_CM_LEN: begin
					skip_d  = {7'd0, cm_count};
					hold_d  = {4'd0, PH_ET_HI};
					phase_d = PH_SKIP;
				end
				PH_ET_LO: begin
					if (v == 16'd0) begin
						skip_d  = tse_pkg::SNI_HEAD_REST;
						hold_d  = {4'd0, PH_NL_HI};
						phase_d = PH_SKIP;
					end else begin
						phase_d = PH_EL_HI;
					end
				end
				PH_EL_LO: begin
					if (v == 16'd0) begin
						phase_d = PH_ET_HI;
					end else begin
						skip_d  = v;
						hold_d  = {4'd0, PH_ET_HI};
						phase_d = PH_SKIP;
					end
				end
				PH_NL_LO: begin
					if (v == 16'd0) begin
						res_valid = 1'b1;
						res       = '{8'd0, tse_pkg::ST_EMPTY, 1'b1};
						done_d    = 1'b1;
					end else begin
						rem_d   = v;
						phase_d = PH_NAME;
					end
				end
				PH_NAME: begin
					res_valid = 1'b1;
					if (rem_q <= 16'd1) begin
						rem_d  = '0;
						res    = '{b, tse_pkg::ST_NAME_BYTE, 1'b1};
						done_d = 1'b1;
					end else begin
						rem_d = rem_q - 16'd1;
						res   = '{b, tse_pkg::ST_NAME_BYTE, 1'b0};
					end
				end
				default: begin
				end
			endcase

			// End of record: close it if no final word has gone out yet.
			if (hello_word.record_last) begin
				if (!done_d) begin
					in_sni = (phase_d == PH_NL_HI) || (phase_d == PH_NL_LO) ||
						(phase_d == PH_NAME) || (phase_q == PH_NAME) ||
						((phase_d == PH_SKIP) && (hold_d == {4'd0, PH_NL_HI}));
					res_valid = 1'b1;
					res = '{8'd0, in_sni ? tse_pkg::ST_TRUNCATED : tse_pkg::ST_NOT_FOUND,
						1'b1};
				end
				phase_d = PH_SKIP;
				skip_d  = tse_pkg::HEAD_BYTES;
				hold_d  = '0;
				rem_d   = '0;
				done_d  = 1'b0;
			end
		end
	end

	// Parse state registers, advanced once per accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
			skip_q  <= tse_pkg::HEAD_BYTES;
			hold_q  <= '0;
			rem_q   <= '0;
			done_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			skip_q  <= skip_d;
			hold_q  <= hold_d;
			rem_q   <= rem_d;
			done_q  <= done_d;
		end
	end

	// Output register with a skid register behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || pop) begin
			out_valid_q <= accept && res_valid;
		end else if (accept && res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload of the two registers; no reset needed.
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (!out_valid_q || pop) begin
			out_q <= res;
		end else begin
			skid_q <= res;
		end
	end

endmodule

// ----- rtl/tse_chk.sv -----
// ----------------------------------------------------------------------------
// TLS server name extractor checker
// Port-level assertions on the result channel and on input back-pressure.
// ----------------------------------------------------------------------------
module tse_chk (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 hello_valid,
	input  logic                 hello_stall,
	input  tse_pkg::hello_word_t hello_word,
	input  logic                 sni_valid,
	input  logic                 sni_stall,
	input  tse_pkg::sni_word_t   sni_word
);

	// A stalled result word stays on the port unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sni_valid && sni_stall |=> sni_valid && $stable(sni_word))
		else $error("Stalled result word changed or vanished.");

	// A stalled hello word stays offered unchanged.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hello_valid && hello_stall |=> hello_valid && $stable(hello_word))
		else $error("Stalled hello word changed or vanished.");

	// A status word always closes the record.
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		sni_valid && (sni_word.status != tse_pkg::ST_NAME_BYTE) |-> sni_word.name_last)
		else $error("Status word without name_last.");

	// A status word carries no name byte.
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		sni_valid && (sni_word.status != tse_pkg::ST_NAME_BYTE) |->
			(sni_word.name_byte == 8'd0))
		else $error("Status word with a non-zero name byte.");

	// The input side is only held off after the result side was stalled.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(hello_stall) |-> $past(sni_valid && sni_stall))
		else $error("Input stall raised without a stalled result.");

endmodule

bind tls_sni_extractor_top tse_chk u_tse_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.hello_valid (hello_valid),
	.hello_stall (hello_stall),
	.hello_word  (hello_word),
	.sni_valid   (sni_valid),
	.sni_stall   (sni_stall),
	.sni_word    (sni_word)
);

// ----- tb/tse_sni_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Server name extractor checker
// Watches the hello and sni channels of the extractor, runs its own parser
// on every accepted byte to work out the result words it should produce, and
// compares each accepted result word, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module tse_sni_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 hello_valid,
	input  logic                 hello_stall,
	input  tse_pkg::hello_word_t hello_word,
	input  logic                 sni_valid,
	input  logic                 sni_stall,
	input  tse_pkg::sni_word_t   sni_word,
	output int                   error_count,
	output int                   words_due,
	output int                   words_checked
);

	// Where the parser stands within the ClientHello record.
	typedef enum logic [3:0] {
		SID_LENGTH  = 4'd0,
		SKIP_BYTES  = 4'd1,
		SUITES_HI   = 4'd2,
		SUITES_LO   = 4'd3,
		COMP_LENGTH = 4'd4,
		EXT_TYPE_HI = 4'd5,
		EXT_TYPE_LO = 4'd6,
		EXT_LEN_HI  = 4'd7,
		EXT_LEN_LO  = 4'd8,
		NAME_LEN_HI = 4'd9,
		NAME_LEN_LO = 4'd10,
		NAME_BODY   = 4'd11
	} hello_phase_t;

	hello_phase_t phase;
	hello_phase_t resume_phase;
	logic [15:0]  skip_left;
	logic [7:0]   length_hi;
	logic [15:0]  name_left;
	logic         record_closed;

	tse_pkg::sni_word_t sni_due_q[$];
	int                 mismatch_count = 0;
	int                 due_count = 0;
	int                 compared_count = 0;

	assign error_count   = mismatch_count;
	assign words_due     = due_count;
	assign words_checked = compared_count;

	// Back to the start of a record, with the fixed head still to skip.
	task automatic restart_record();
		phase         = SKIP_BYTES;
		resume_phase  = SID_LENGTH;
		skip_left     = tse_pkg::HEAD_BYTES;
		length_hi     = 8'h00;
		name_left     = 16'h0000;
		record_closed = 1'b0;
	endtask

	// Skips a counted run of bytes; a zero count moves straight on.
	task automatic skip_then(input logic [16:0] count, input hello_phase_t next);
		if (count == 17'd0) begin
			phase = next;
		end else begin
			skip_left    = count[15:0];
			resume_phase = next;
			phase        = SKIP_BYTES;
		end
	endtask

	// Advances the parser by one accepted byte and queues any result it causes.
	task automatic parse_hello_byte(input tse_pkg::hello_word_t w);
		hello_phase_t       prior;
		logic [15:0]        field;
		tse_pkg::sni_word_t due;
		logic               produced;
		logic               cut_in_name;

		prior    = phase;
		field    = {length_hi, w.hello_byte};
		produced = 1'b0;
		due      = '0;
		if (record_closed) begin
			// Everything after the closing word is dropped until the record ends.
			if (w.record_last)
				restart_record();
		end else begin
			case (phase)
				SID_LENGTH: skip_then(17'(w.hello_byte), SUITES_HI);
				SKIP_BYTES: begin
					if (skip_left <= 16'd1) begin
						skip_left = 16'd0;
						phase     = resume_phase;
					end else begin
						skip_left = skip_left - 16'd1;
					end
				end
				SUITES_HI, EXT_TYPE_HI, EXT_LEN_HI, NAME_LEN_HI: begin
					length_hi = w.hello_byte;
					phase     = hello_phase_t'(phase + 4'd1);
				end
				SUITES_LO: skip_then(17'(field), COMP_LENGTH);
				// The compression skip also swallows the extensions length.
				COMP_LENGTH: skip_then(17'(w.hello_byte) + 17'(tse_pkg::CM_EXTRA),
					EXT_TYPE_HI);
				EXT_TYPE_LO: begin
					if (field == 16'h0000)
						skip_then(17'(tse_pkg::SNI_HEAD_REST), NAME_LEN_HI);
					else
						phase = EXT_LEN_HI;
				end
				EXT_LEN_LO: skip_then(17'(field), EXT_TYPE_HI);
				NAME_LEN_LO: begin
					if (field == 16'h0000) begin
						produced      = 1'b1;
						due.name_byte = 8'h00;
						due.status    = tse_pkg::ST_EMPTY;
						due.name_last = 1'b1;
						record_closed = 1'b1;
					end else begin
						name_left = field;
						phase     = NAME_BODY;
					end
				end
				NAME_BODY: begin
					produced      = 1'b1;
					due.name_byte = w.hello_byte;
					due.status    = tse_pkg::ST_NAME_BYTE;
					if (name_left <= 16'd1) begin
						name_left     = 16'd0;
						due.name_last = 1'b1;
						record_closed = 1'b1;
					end else begin
						name_left     = name_left - 16'd1;
						due.name_last = 1'b0;
					end
				end
				default: ;
			endcase

			// A record that ends before its closing word closes with a status word instead.
			if (w.record_last) begin
				if (!record_closed) begin
					cut_in_name = (phase == NAME_LEN_HI) || (phase == NAME_LEN_LO) ||
						(phase == NAME_BODY) || (prior == NAME_BODY) ||
						(phase == SKIP_BYTES && resume_phase == NAME_LEN_HI);
					produced      = 1'b1;
					due.name_byte = 8'h00;
					due.status    = cut_in_name ? tse_pkg::ST_TRUNCATED : tse_pkg::ST_NOT_FOUND;
					due.name_last = 1'b1;
				end
				restart_record();
			end
		end
		if (produced)
			sni_due_q.push_back(due);
	endtask

	task automatic flag_mismatch(input string what);
		$display("[%0t] sni word mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	// Compares one accepted result word with the oldest word due.
	task automatic check_sni_word(input tse_pkg::sni_word_t got);
		tse_pkg::sni_word_t want;

		if (sni_due_q.size() == 0) begin
			flag_mismatch($sformatf("unexpected word byte=%02h status=%0d last=%0b",
				got.name_byte, got.status, got.name_last));
		end else begin
			want = sni_due_q.pop_front();
			if (got.name_byte !== want.name_byte)
				flag_mismatch($sformatf("name_byte %02h, expected %02h",
					got.name_byte, want.name_byte));
			if (got.status !== want.status)
				flag_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
			if (got.name_last !== want.name_last)
				flag_mismatch($sformatf("name_last %0b, expected %0b",
					got.name_last, want.name_last));
			compared_count++;
		end
	endtask

	// Both channels are sampled at the rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_record();
			sni_due_q.delete();
			due_count = 0;
		end else begin
			if (hello_valid && !hello_stall)
				parse_hello_byte(hello_word);
			if (sni_valid && !sni_stall)
				check_sni_word(sni_word);
			due_count = sni_due_q.size();
		end
	end

endmodule

// ----- tb/tls_sni_extractor_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Server name extractor testbench
// Feeds the extractor directed and random ClientHello records, whole, cut
// short and corrupted, under three idling mixes and one long output hold-off,
// while a checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tls_sni_extractor_top_tb;

	localparam int CYCLE_LIMIT = 500000;
	localparam int PHASE_BYTES = 40;
	localparam int HOLD_CYCLES = 400;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 hello_valid = 1'b0;
	logic                 hello_stall;
	tse_pkg::hello_word_t hello_word = '0;
	logic                 sni_valid;
	logic                 sni_stall = 1'b0;
	tse_pkg::sni_word_t   sni_word;

	int error_count;
	int words_due;
	int words_checked;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int bytes_sent = 0;
	int records = 0;
	int cycles = 0;

	// Bytes of the record being put together.
	logic [7:0] rec_bytes[$];

	tls_sni_extractor_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.hello_valid (hello_valid),
		.hello_stall (hello_stall),
		.hello_word  (hello_word),
		.sni_valid   (sni_valid),
		.sni_stall   (sni_stall),
		.sni_word    (sni_word)
	);

	tse_sni_checker sni_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.hello_valid   (hello_valid),
		.hello_stall   (hello_stall),
		.hello_word    (hello_word),
		.sni_valid     (sni_valid),
		.sni_stall     (sni_stall),
		.sni_word      (sni_word),
		.error_count   (error_count),
		.words_due     (words_due),
		.words_checked (words_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: random stalls, or a long hold-off when one has been asked for.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_requests > hold_served) begin
				hold_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				sni_stall <= 1'b1;
			end else begin
				sni_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// Run limit.
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timed out after %0d cycles", cycles);
		$display("DONE: errors detected");
		$finish;
	end

	function automatic void add_random(input int count);
		repeat (count) rec_bytes.push_back(8'($urandom_range(0, 255)));
	endfunction

	function automatic void add16(input logic [15:0] value);
		rec_bytes.push_back(value[15:8]);
		rec_bytes.push_back(value[7:0]);
	endfunction

	// Record and handshake headers, version and random, then the session ID,
	// cipher suites, compression methods and the extensions length.
	function automatic void add_head(input int sid_len, input int cs_len, input int cm_len);
		rec_bytes.push_back(8'h16);
		rec_bytes.push_back(8'h03);
		rec_bytes.push_back(8'h01);
		add_random(40);
		rec_bytes.push_back(8'(sid_len));
		add_random(sid_len);
		add16(16'(cs_len));
		add_random(cs_len);
		rec_bytes.push_back(8'(cm_len));
		add_random(cm_len);
		add16(16'($urandom_range(0, 65535)));
	endfunction

	// Any other extension; long bodies are only begun, since the record is
	// expected to end inside them.
	function automatic void add_ext(input logic [15:0] ext_type, input logic [15:0] ext_len);
		add16(ext_type);
		add16(ext_len);
		add_random((ext_len > 16'd16) ? 3 : int'(ext_len));
	endfunction

	// Server name extension announcing name_len bytes, of which sent follow.
	function automatic void add_sni(input logic [15:0] name_len, input int sent);
		add16(16'h0000);
		add16(name_len + 16'd5);
		add16(name_len + 16'd3);
		rec_bytes.push_back(8'h00);
		add16(name_len);
		add_random(sent);
	endfunction

	task automatic set_pace(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	// Offers one word and holds it until it is taken. Called at a falling edge.
	task automatic offer_byte(input logic [7:0] value, input logic fin);
		tse_pkg::hello_word_t w;

		w.hello_byte  = value;
		w.record_last = fin;
		while ($urandom_range(99) < send_idle_pct) begin
			hello_valid <= 1'b0;
			@(negedge clk);
		end
		hello_word  <= w;
		hello_valid <= 1'b1;
		@(posedge clk);
		while (hello_stall) @(posedge clk);
		@(negedge clk);
		bytes_sent++;
	endtask

	// Sends the first cut bytes of the record, the last of them marked final.
	task automatic send_record(input int cut);
		for (int i = 0; i < cut; i++)
			offer_byte(rec_bytes[i], i == cut - 1);
		rec_bytes.delete();
		records++;
	endtask

	// Stops offering until every result word due has arrived.
	task automatic pause_sender();
		hello_valid <= 1'b0;
		wait (words_due == 0);
		@(negedge clk);
	endtask

	task automatic run_directed_hellos();
		int mark;

		// Plain name of three bytes.
		add_head(0, 2, 1);
		add_sni(16'd3, 3);
		send_record(rec_bytes.size());
		// Empty name after another extension.
		add_head(1, 4, 0);
		add_ext(16'h0010, 16'd2);
		add_sni(16'd0, 0);
		send_record(rec_bytes.size());
		// No server name at all; the last extension is empty.
		add_head(0, 2, 1);
		add_ext(16'h000a, 16'd4);
		add_ext(16'hffff, 16'd0);
		send_record(rec_bytes.size());
		// Records that end inside the head: five bytes, one byte, and on the
		// session ID length.
		add_random(5);
		send_record(5);
		add_random(1);
		send_record(1);
		add_head(0, 2, 1);
		send_record(44);
		// Ends in the server name header, then on the name length high byte.
		add_head(0, 0, 0);
		mark = rec_bytes.size();
		add_sni(16'd5, 5);
		send_record(mark + 4);
		add_head(0, 0, 0);
		mark = rec_bytes.size();
		add_sni(16'd5, 5);
		send_record(mark + 8);
		// Final byte arrives as a name byte while more are due.
		add_head(3, 2, 2);
		mark = rec_bytes.size();
		add_sni(16'd6, 6);
		send_record(mark + 12);
		// Bytes after a complete name are dropped.
		add_head(0, 2, 1);
		add_sni(16'd2, 2);
		add_random(4);
		send_record(rec_bytes.size());
		// A suite list longer than 255 bytes and the longest compression list,
		// then an extension with the longest length cut short.
		add_head(4, 256, 255);
		add_ext(16'h0100, 16'hffff);
		send_record(rec_bytes.size());
		// Longest name length, cut after three bytes.
		add_head(2, 2, 1);
		add_ext(16'h0001, 16'd1);
		add_sni(16'hffff, 3);
		send_record(rec_bytes.size());
		// Name of one byte, which is also the final byte.
		add_head(0, 2, 1);
		add_sni(16'd1, 1);
		send_record(rec_bytes.size());
		// Name length of 256, whose low byte is zero, cut after three bytes.
		add_head(0, 2, 1);
		add_sni(16'h0100, 3);
		send_record(rec_bytes.size());
	endtask

	// Mostly well-formed records with random content; some cut short, some
	// with one byte corrupted, and some plain noise.
	task automatic send_random_hello();
		int kind;
		int sid_len;
		int name_len;
		int cut;
		int spot;

		kind = $urandom_range(99);
		if (kind >= 88) begin
			add_random($urandom_range(1, 50));
			send_record(rec_bytes.size());
		end else begin
			sid_len = ($urandom_range(19) == 0) ? $urandom_range(9, 32) :
				$urandom_range(0, 8);
			add_head(sid_len, 2 * $urandom_range(0, 4), $urandom_range(0, 3));
			repeat ($urandom_range(0, 2))
				add_ext(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 4)));
			if ($urandom_range(9) != 0) begin
				name_len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
				add_sni(16'(name_len), name_len);
			end
			add_random($urandom_range(0, 2));
			cut = rec_bytes.size();
			if (kind >= 60 && kind < 78)
				cut = $urandom_range(1, rec_bytes.size());
			if (kind >= 78) begin
				spot = $urandom_range(43, rec_bytes.size() - 1);
				rec_bytes[spot] = 8'($urandom_range(0, 255));
			end
			send_record(cut);
		end
	endtask

	task automatic run_random_phase(input int send_pct, input int recv_pct);
		int stop_at;

		set_pace(send_pct, recv_pct);
		stop_at = bytes_sent + PHASE_BYTES;
		while (bytes_sent < stop_at) send_random_hello();
		pause_sender();
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_pace(28, 82);
		run_directed_hellos();
		pause_sender();

		// Long hold-off on the output while a name keeps arriving, so that the
		// block fills up and stalls its input.
		set_pace(0, 0);
		hold_requests++;
		add_head(0, 2, 1);
		add_sni(16'd20, 20);
		send_record(rec_bytes.size());
		pause_sender();

		run_random_phase(28, 82);
		run_random_phase(82, 28);
		run_random_phase(0, 0);

		wait (words_due == 0);
		repeat (20) @(posedge clk);
		$display("Run covered %0d ClientHello records: %0d bytes in, %0d result words compared.",
			records, bytes_sent, words_checked);
		$display("Directed edge cases, a long output hold-off and three idling mixes were used.");
		if (error_count == 0 && words_due == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/tse_pkg.sv
rtl/tls_sni_extractor_top.sv
rtl/tse_chk.sv
tb/tse_sni_checker.sv
tb/tls_sni_extractor_top_tb.sv
